@@ design/pcac_pkg.sv @@
// shared types, opcodes and decode helpers of the accumulator machine
package pcac_pkg;

  // request operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_EXEC  = 2'd1;
  localparam logic [1:0] OP_SETPC = 2'd2;

  // instruction opcodes
  localparam logic [7:0] OPC_LOAD_I  = 8'd0;
  localparam logic [7:0] OPC_LOAD_D  = 8'd64;
  localparam logic [7:0] OPC_LOAD_X  = 8'd192;
  localparam logic [7:0] OPC_ADD_I   = 8'd32;
  localparam logic [7:0] OPC_ADD_D   = 8'd96;
  localparam logic [7:0] OPC_ADD_X   = 8'd224;
  localparam logic [7:0] OPC_SUB_I   = 8'd33;
  localparam logic [7:0] OPC_SUB_D   = 8'd97;
  localparam logic [7:0] OPC_SUB_X   = 8'd225;
  localparam logic [7:0] OPC_NAND_I  = 8'd34;
  localparam logic [7:0] OPC_NAND_D  = 8'd98;
  localparam logic [7:0] OPC_NAND_X  = 8'd226;
  localparam logic [7:0] OPC_JUMP    = 8'd16;
  localparam logic [7:0] OPC_BRN     = 8'd17;
  localparam logic [7:0] OPC_BRZ     = 8'd18;
  localparam logic [7:0] OPC_STORE_D = 8'd72;
  localparam logic [7:0] OPC_STORE_X = 8'd200;
  localparam logic [7:0] OPC_IN_D    = 8'd73;
  localparam logic [7:0] OPC_IN_X    = 8'd201;
  localparam logic [7:0] OPC_OUT_D   = 8'd65;
  localparam logic [7:0] OPC_OUT_X   = 8'd193;

  // alu function in the low six opcode bits
  localparam logic [5:0] KIND_LOAD = 6'd0;
  localparam logic [5:0] KIND_ADD  = 6'd32;
  localparam logic [5:0] KIND_SUB  = 6'd33;

  // addressing mode in the top two opcode bits
  localparam logic [1:0] MODE_IMM = 2'd0;
  localparam logic [1:0] MODE_DIR = 2'd1;
  localparam logic [1:0] MODE_IND = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_ARG,
    S_PTR,
    S_DAT,
    S_FIN
  } pcac_state_t;

  // one access to the single-port memory
  typedef struct packed {
    logic       en;
    logic       we;
    logic [7:0] addr;
    logic [7:0] wdata;
  } mem_req_t;

  function automatic logic opc_legal(input logic [7:0] code);
    logic ok;
    case (code)
      OPC_LOAD_I, OPC_LOAD_D, OPC_LOAD_X,
      OPC_ADD_I, OPC_ADD_D, OPC_ADD_X,
      OPC_SUB_I, OPC_SUB_D, OPC_SUB_X,
      OPC_NAND_I, OPC_NAND_D, OPC_NAND_X,
      OPC_JUMP, OPC_BRN, OPC_BRZ,
      OPC_STORE_D, OPC_STORE_X, OPC_IN_D, OPC_IN_X,
      OPC_OUT_D, OPC_OUT_X: ok = 1'b1;
      default:              ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [7:0] alu(input logic [7:0] code, input logic [7:0] acc,
                                     input logic [7:0] x);
    logic [7:0] res;
    case (code[5:0])
      KIND_LOAD: res = x;
      KIND_ADD:  res = acc + x;
      KIND_SUB:  res = acc - x;
      default:   res = ~(acc & x);
    endcase
    return res;
  endfunction

endpackage

@@ design/pcac_mem.sv @@
// single-port main memory, registered read, addresses wrap at the depth
module pcac_mem #(
  parameter int unsigned MEMORY_DEPTH = 256
) (
  input  logic              clk,
  input  pcac_pkg::mem_req_t req,
  output logic [7:0]        rdata
);
  import pcac_pkg::*;

  localparam int unsigned AW = $clog2(MEMORY_DEPTH);
  localparam int unsigned WW = 12;

  logic [7:0]    mem [MEMORY_DEPTH];
  logic [7:0]    rdata_r;
  logic [AW-1:0] idx;

  // address modulo depth: quotient below 16, four compare and subtract steps
  function automatic logic [AW-1:0] wrap(input logic [7:0] a);
    logic [WW-1:0] v;
    logic [WW-1:0] m;
    v = {{(WW-8){1'b0}}, a};
    for (int k = 3; k >= 0; k--) begin
      m = WW'(MEMORY_DEPTH) << k;
      if (v >= m) begin
        v = v - m;
      end
    end
    return v[AW-1:0];
  endfunction

  assign idx = wrap(req.addr);

  always_ff @(posedge clk) begin
    if (req.en && req.we) begin
      mem[idx] <= req.wdata;
    end
    if (req.en && !req.we) begin
      rdata_r <= mem[idx];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/paper_computer_accumulator_cpu_unit.sv @@
// top level of the eight-bit accumulator machine: sequencer, registers, result stage
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  operation, address, value
//   out_     output     out_valid/ out_stall pc_now, acc_now, out_valid, out_byte,
//                                            in_used, halted, fault
//
// one request at a time; the wait from one accept to the next with the result side free
// is set by the number of accesses to the single-port memory, rising from write, set pc,
// blocked, illegal, jump/branch/immediate/direct store or in, direct alu or out, indirect
// synchronous active-low reset clears pc, accumulator, fault and the handshake;
// memory contents are undefined until written, no clearing pass
// a new request is taken while the previous result still waits in the output stage
module paper_computer_accumulator_cpu_unit #(
  parameter int unsigned MEMORY_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_address,
  input  logic [7:0] in_value,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_pc_now,
  output logic [7:0] out_acc_now,
  output logic       out_out_valid,
  output logic [7:0] out_out_byte,
  output logic       out_in_used,
  output logic       out_halted,
  output logic       out_fault
);
  import pcac_pkg::*;

  pcac_state_t state_r, state_nxt;

  // architectural state
  logic [7:0] pc_r, pc_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic       fault_r, fault_nxt;

  // per-request working registers
  logic [1:0] op_r, op_nxt;
  logic [7:0] val_r, val_nxt;
  logic [7:0] code_r, code_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       iu_r, iu_nxt;

  // result stage
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] res_pc_r, res_acc_r, res_ob_r;
  logic       res_ov_r, res_iu_r, res_halt_r, res_fault_r;

  logic       in_acc;
  logic       res_load;
  logic [7:0] rd_data;
  logic [7:0] pc_inc;
  mem_req_t   mreq;

  pcac_mem #(
    .MEMORY_DEPTH(MEMORY_DEPTH)
  ) u_mem (
    .clk  (clk),
    .req  (mreq),
    .rdata(rd_data)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign pc_inc   = pc_r + 8'd1;
  // result stage free when empty or being drained this cycle
  assign res_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt  = state_r;
    pc_nxt     = pc_r;
    acc_nxt    = acc_r;
    fault_nxt  = fault_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    code_nxt   = code_r;
    ov_nxt     = ov_r;
    ob_nxt     = ob_r;
    iu_nxt     = iu_r;
    mreq       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_operation;
          val_nxt   = in_value;
          ov_nxt    = 1'b0;
          ob_nxt    = 8'd0;
          iu_nxt    = 1'b0;
          state_nxt = S_FIN;
          case (in_operation)
            OP_WRITE: begin
              mreq.en    = 1'b1;
              mreq.we    = 1'b1;
              mreq.addr  = in_address;
              mreq.wdata = in_value;
            end
            OP_SETPC: begin
              pc_nxt    = in_address;
              fault_nxt = 1'b0;
            end
            OP_EXEC: begin
              // halted or faulted machine ignores the step
              if (!fault_r && pc_r != 8'd0) begin
                mreq.en   = 1'b1;
                mreq.addr = pc_r;
                state_nxt = S_OP;
              end
            end
            default: ;
          endcase
        end
      end

      S_OP: begin
        // opcode arrives; pc moves onto the operand byte
        code_nxt = rd_data;
        pc_nxt   = pc_inc;
        if (opc_legal(rd_data)) begin
          mreq.en   = 1'b1;
          mreq.addr = pc_inc;
          state_nxt = S_ARG;
        end else begin
          fault_nxt = 1'b1;
          state_nxt = S_FIN;
        end
      end

      S_ARG: begin
        // operand byte b arrives
        state_nxt = S_FIN;
        pc_nxt    = pc_inc;
        case (code_r)
          OPC_JUMP: pc_nxt = rd_data;
          OPC_BRN:  pc_nxt = acc_r[7] ? rd_data : pc_inc;
          OPC_BRZ:  pc_nxt = (acc_r == 8'd0) ? rd_data : pc_inc;
          OPC_STORE_D: begin
            mreq.en    = 1'b1;
            mreq.we    = 1'b1;
            mreq.addr  = rd_data;
            mreq.wdata = acc_r;
          end
          OPC_IN_D: begin
            mreq.en    = 1'b1;
            mreq.we    = 1'b1;
            mreq.addr  = rd_data;
            mreq.wdata = val_r;
            iu_nxt     = 1'b1;
          end
          default: begin
            if (code_r[7:6] == MODE_IMM) begin
              acc_nxt = alu(code_r, acc_r, rd_data);
            end else begin
              mreq.en   = 1'b1;
              mreq.addr = rd_data;
              pc_nxt    = pc_r;
              state_nxt = (code_r[7:6] == MODE_IND) ? S_PTR : S_DAT;
            end
          end
        endcase
      end

      S_PTR: begin
        // pointer d arrives
        case (code_r)
          OPC_STORE_X: begin
            mreq.en    = 1'b1;
            mreq.we    = 1'b1;
            mreq.addr  = rd_data;
            mreq.wdata = acc_r;
            pc_nxt     = pc_inc;
            state_nxt  = S_FIN;
          end
          OPC_IN_X: begin
            mreq.en    = 1'b1;
            mreq.we    = 1'b1;
            mreq.addr  = rd_data;
            mreq.wdata = val_r;
            iu_nxt     = 1'b1;
            pc_nxt     = pc_inc;
            state_nxt  = S_FIN;
          end
          default: begin
            mreq.en   = 1'b1;
            mreq.addr = rd_data;
            state_nxt = S_DAT;
          end
        endcase
      end

      S_DAT: begin
        // operand x arrives
        pc_nxt    = pc_inc;
        state_nxt = S_FIN;
        if (code_r == OPC_OUT_D || code_r == OPC_OUT_X) begin
          ov_nxt = 1'b1;
          ob_nxt = rd_data;
        end else begin
          acc_nxt = alu(code_r, acc_r, rd_data);
        end
      end

      S_FIN: begin
        if (res_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= 8'd0;
      acc_r       <= 8'd0;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      acc_r       <= acc_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    val_r  <= val_nxt;
    code_r <= code_nxt;
    ov_r   <= ov_nxt;
    ob_r   <= ob_nxt;
    iu_r   <= iu_nxt;
    if (res_load) begin
      res_pc_r    <= pc_r;
      res_acc_r   <= acc_r;
      res_ov_r    <= ov_r;
      res_ob_r    <= ob_r;
      res_iu_r    <= iu_r;
      res_halt_r  <= (pc_r == 8'd0);
      res_fault_r <= fault_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pc_now    = res_pc_r;
  assign out_acc_now   = res_acc_r;
  assign out_out_valid = res_ov_r;
  assign out_out_byte  = res_ob_r;
  assign out_in_used   = res_iu_r;
  assign out_halted    = res_halt_r;
  assign out_fault     = res_fault_r;

`ifndef NO_ASSERTIONS
  // a set-pc request always reports a cleared fault
  a_setpc_clears_fault: assert property (@(posedge clk) disable iff (!rst_n)
    res_load && op_r == OP_SETPC |=> out_fault == 1'b0)
    else $error("set pc left fault set");

  // emitted byte is zero unless an out instruction ran
  a_out_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_valid |-> out_out_byte == 8'd0)
    else $error("out byte without out instruction");

  // memory writes come only from a write request or a store/in step
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.en && mreq.we |-> state_r == S_IDLE || state_r == S_ARG || state_r == S_PTR)
    else $error("memory write from unexpected state");

  // no second result is produced while one is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_pc_now) && $stable(out_acc_now))
    else $error("stalled result overwritten");
`endif

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench of the eight-bit accumulator machine
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pcac_pkg::*;

  // request code that the block must ignore, and an opcode outside the instruction set
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [7:0] OPC_ILLEGAL = 8'd1;

  // run shape: total requests, point where idling stops, length of the long receiver hold
  localparam int unsigned RUN_REQUESTS = 1200;
  localparam int unsigned QUIET_FROM   = 1050;
  localparam int unsigned LONG_HOLD    = 150;

  // every legal instruction, drawn from when random programs are built
  localparam logic [7:0] LEGAL_OPS [21] = '{
    OPC_LOAD_I, OPC_LOAD_D, OPC_LOAD_X, OPC_ADD_I, OPC_ADD_D, OPC_ADD_X,
    OPC_SUB_I, OPC_SUB_D, OPC_SUB_X, OPC_NAND_I, OPC_NAND_D, OPC_NAND_X,
    OPC_JUMP, OPC_BRN, OPC_BRZ, OPC_STORE_D, OPC_STORE_X, OPC_IN_D, OPC_IN_X,
    OPC_OUT_D, OPC_OUT_X
  };

  // machine state as reported after one request
  typedef struct packed {
    logic [7:0] pc;
    logic [7:0] acc;
    logic       emitted;
    logic [7:0] emit_byte;
    logic       took_input;
    logic       halted;
    logic       fault;
  } snap_t;

  // one directed request with the state it must leave behind
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] addr;
    logic [7:0] value;
    snap_t      want;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_operation;
  logic [7:0] in_address;
  logic [7:0] in_value;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_pc_now;
  logic [7:0] out_acc_now;
  logic       out_out_valid;
  logic [7:0] out_out_byte;
  logic       out_in_used;
  logic       out_halted;
  logic       out_fault;

  // predictor copy of the machine
  logic [7:0] pc_q;
  logic [7:0] acc_q;
  logic       flt_q;
  logic [7:0] mem_img [256];

  snap_t       snap_due [$];   // states the block still owes, oldest first
  int unsigned sent;           // requests accepted so far
  int unsigned errors;
  bit          idling;         // random gaps and stalls allowed
  bit          hold_req;       // asks the receiver for one long hold-off

  // directed part: after-reset behavior, halted and faulted requests, illegal opcode,
  // fault cleared by set pc, ignored request code, extremes of every field, pc wrap
  stim_row_t dir_tab [25] = '{
    // halted right after reset: nothing runs, writes still land
    '{OP_SETPC,  8'h00, 8'h00,        '{8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0}},
    '{OP_EXEC,   8'h00, 8'h00,        '{8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0}},
    '{OP_UNUSED, 8'hff, 8'hff,        '{8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0}},
    '{OP_WRITE,  8'hff, 8'hff,        '{8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0}},
    // illegal opcode raises the fault and blocks further steps
    '{OP_WRITE,  8'h40, OPC_ILLEGAL,  '{8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0}},
    '{OP_SETPC,  8'h40, 8'h00,        '{8'h40, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{OP_EXEC,   8'h00, 8'h00,        '{8'h41, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1}},
    '{OP_EXEC,   8'h00, 8'h00,        '{8'h41, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1}},
    '{OP_WRITE,  8'h41, OPC_LOAD_I,   '{8'h41, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1}},
    '{OP_WRITE,  8'h42, 8'h80,        '{8'h41, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1}},
    // set pc clears the fault, then load, and a taken negative branch to zero halts
    '{OP_SETPC,  8'h41, 8'h00,        '{8'h41, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{OP_EXEC,   8'h00, 8'h00,        '{8'h43, 8'h80, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{OP_WRITE,  8'h43, OPC_BRN,      '{8'h43, 8'h80, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{OP_WRITE,  8'h44, 8'h00,        '{8'h43, 8'h80, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{OP_EXEC,   8'h00, 8'h00,        '{8'h00, 8'h80, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0}},
    // out from the top address, then in to address zero
    '{OP_WRITE,  8'h50, OPC_OUT_D,    '{8'h00, 8'h80, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0}},
    '{OP_WRITE,  8'h51, 8'hff,        '{8'h00, 8'h80, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0}},
    '{OP_WRITE,  8'h52, OPC_IN_D,     '{8'h00, 8'h80, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0}},
    '{OP_WRITE,  8'h53, 8'h00,        '{8'h00, 8'h80, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0}},
    '{OP_SETPC,  8'h50, 8'h00,        '{8'h50, 8'h80, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{OP_EXEC,   8'h00, 8'h00,        '{8'h52, 8'h80, 1'b1, 8'hff, 1'b0, 1'b0, 1'b0}},
    '{OP_EXEC,   8'h00, 8'hab,        '{8'h54, 8'h80, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0}},
    // illegal opcode at the top address: pc wraps to zero, halted and faulted at once
    '{OP_SETPC,  8'hff, 8'h00,        '{8'hff, 8'h80, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{OP_EXEC,   8'h00, 8'h00,        '{8'h00, 8'h80, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1}},
    '{OP_SETPC,  8'h00, 8'h00,        '{8'h00, 8'h80, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0}}
  };

  paper_computer_accumulator_cpu_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_address    (in_address),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pc_now    (out_pc_now),
    .out_acc_now   (out_acc_now),
    .out_out_valid (out_out_valid),
    .out_out_byte  (out_out_byte),
    .out_in_used   (out_in_used),
    .out_halted    (out_halted),
    .out_fault     (out_fault)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // one request through the machine: fetch, advance pc, execute
  task automatic machine_step(input logic [1:0] op, input logic [7:0] addr,
                              input logic [7:0] value, output snap_t res);
    logic [7:0] code;
    logic [7:0] arg;
    logic [7:0] ptr;
    logic [7:0] opnd;
    res = '0;
    case (op)
      OP_WRITE: mem_img[addr] = value;
      OP_SETPC: begin
        pc_q  = addr;
        flt_q = 1'b0;
      end
      OP_EXEC: begin
        // halted or faulted machines do not step
        if (!flt_q && pc_q != 8'h00) begin
          code = mem_img[pc_q];
          pc_q = pc_q + 8'd1;
          arg  = mem_img[pc_q];
          ptr  = mem_img[arg];
          case (code[7:6])
            MODE_IMM: opnd = arg;
            MODE_DIR: opnd = ptr;
            MODE_IND: opnd = mem_img[ptr];
            default:  opnd = 8'h00;
          endcase
          case (code)
            OPC_JUMP: pc_q = arg;
            OPC_BRN:  pc_q = acc_q[7] ? arg : pc_q + 8'd1;
            OPC_BRZ:  pc_q = (acc_q == 8'h00) ? arg : pc_q + 8'd1;
            OPC_LOAD_I, OPC_LOAD_D, OPC_LOAD_X, OPC_ADD_I, OPC_ADD_D, OPC_ADD_X,
            OPC_SUB_I, OPC_SUB_D, OPC_SUB_X, OPC_NAND_I, OPC_NAND_D, OPC_NAND_X: begin
              case (code[5:0])
                KIND_LOAD: acc_q = opnd;
                KIND_ADD:  acc_q = acc_q + opnd;
                KIND_SUB:  acc_q = acc_q - opnd;
                default:   acc_q = ~(acc_q & opnd);
              endcase
              pc_q = pc_q + 8'd1;
            end
            OPC_STORE_D, OPC_STORE_X: begin
              mem_img[(code == OPC_STORE_D) ? arg : ptr] = acc_q;
              pc_q = pc_q + 8'd1;
            end
            OPC_IN_D, OPC_IN_X: begin
              mem_img[(code == OPC_IN_D) ? arg : ptr] = value;
              res.took_input = 1'b1;
              pc_q = pc_q + 8'd1;
            end
            OPC_OUT_D, OPC_OUT_X: begin
              res.emitted   = 1'b1;
              res.emit_byte = opnd;
              pc_q = pc_q + 8'd1;
            end
            // illegal opcode: pc stays past the opcode byte
            default: flt_q = 1'b1;
          endcase
        end
      end
      default: ;  // unused request code leaves the machine alone
    endcase
    res.pc     = pc_q;
    res.acc    = acc_q;
    res.halted = (pc_q == 8'h00);
    res.fault  = flt_q;
  endtask

  // offer one request, wait for it to be taken, then record the state it must produce;
  // a typed expectation replaces the predicted one for directed rows
  task automatic send(input logic [1:0] op, input logic [7:0] addr, input logic [7:0] value,
                      input bit typed = 1'b0, input snap_t want = '0);
    snap_t predicted;
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_address   <= addr;
    in_value     <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    machine_step(op, addr, value, predicted);
    snap_due.push_back(typed ? want : predicted);
    sent++;
  endtask

  // a short random program of legal instructions, loaded, started and stepped
  task automatic run_program();
    logic [7:0] base;
    logic [7:0] opc;
    logic [7:0] arg;
    int         n;
    base = 8'($urandom_range(1, 230));
    n    = $urandom_range(3, 10);
    for (int i = 0; i < n; i++) begin
      opc = LEGAL_OPS[$urandom_range(0, 20)];
      if (opc == OPC_JUMP || opc == OPC_BRN || opc == OPC_BRZ) begin
        // branches mostly land on an instruction of this program, sometimes halt or wander
        case ($urandom_range(0, 7))
          0:       arg = 8'h00;
          1:       arg = 8'($urandom_range(0, 255));
          default: arg = base + 8'(2 * $urandom_range(0, n - 1));
        endcase
      end else begin
        arg = 8'($urandom_range(0, 255));
      end
      send(OP_WRITE, base + 8'(2 * i), opc);
      send(OP_WRITE, base + 8'(2 * i + 1), arg);
    end
    send(OP_SETPC, base, 8'($urandom_range(0, 255)));
    repeat ($urandom_range(n, 3 * n))
      send(OP_EXEC, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // stimulus
  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_WRITE;
    in_address   <= 8'h00;
    in_value     <= 8'h00;
    pc_q   = 8'h00;
    acc_q  = 8'h00;
    flt_q  = 1'b0;
    sent   = 0;
    errors = 0;
    idling = 1'b1;
    hold_req = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // fill the whole memory first so no step ever reads an unwritten byte
    for (int a = 0; a < 256; a++) send(OP_WRITE, 8'(a), 8'($urandom_range(0, 255)));

    foreach (dir_tab[i])
      send(dir_tab[i].op, dir_tab[i].addr, dir_tab[i].value, 1'b1, dir_tab[i].want);

    // receiver holds off for a long stretch while programs keep coming
    hold_req = 1'b1;

    while (sent < RUN_REQUESTS) begin
      // some phases run without gaps, the tail of the run never idles
      idling = ($urandom_range(0, 3) != 0) && (sent < QUIET_FROM);
      if ($urandom_range(0, 7) == 0) begin
        // noise: any request code, including the unused one, on random memory
        repeat ($urandom_range(1, 4))
          send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
      end else begin
        run_program();
      end
    end
    in_valid <= 1'b0;

    // drain, then give the block time to show any extra result
    while (snap_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // result side stall: random bursts, plus the one long hold-off
  initial begin
    int  hold_left;
    int  burst_left;
    bit  stall_next;
    hold_left  = 0;
    burst_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        stall_next = 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(1, 8) - 1;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // compare every taken result with the oldest owed state
  always @(posedge clk) begin
    snap_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (snap_due.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        want = snap_due.pop_front();
        check_field("pc_now", want.pc, out_pc_now);
        check_field("acc_now", want.acc, out_acc_now);
        check_field("out_valid", 8'(want.emitted), 8'(out_out_valid));
        check_field("out_byte", want.emit_byte, out_out_byte);
        check_field("in_used", 8'(want.took_input), 8'(out_in_used));
        check_field("halted", 8'(want.halted), 8'(out_halted));
        check_field("fault", 8'(want.fault), 8'(out_fault));
      end
    end
  end

endmodule

@@ sim.f @@
design/pcac_pkg.sv
design/pcac_mem.sv
design/paper_computer_accumulator_cpu_unit.sv
tb/tb_top.sv
